// File: src/bbl_pkg.sv
package bbl_pkg;

    localparam int unsigned HASH_W = 64;
    localparam int unsigned SIZE_W = 24;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned TICK_W = 32;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned BUDGET_W = 12;
    localparam int unsigned MIB_SHIFT = 20;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 12'd256;

    typedef enum logic [1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_READY   = 2'd1,
        KIND_FAILED  = 2'd2,
        KIND_REBUILD = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_MISSING = 2'd0,
        ST_READY   = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] check;
        logic              ready;
        logic [CODE_W-1:0] reason;
        logic [SIZE_W-1:0] size;
        logic [TICK_W-1:0] tick;
    } t_entry;

    typedef struct packed {
        logic [1:0]        status;
        logic [CODE_W-1:0] failure_out;
        logic              collision;
        logic              evicted;
        logic [HASH_W-1:0] evicted_hash;
    } t_result;

    typedef struct packed {
        logic   match_found;
        t_entry match_entry;
        logic   free_found;
        logic   old_found;
        t_entry old_entry;
    } t_scan;

endpackage

// File: src/bbl_in_if.sv
interface bbl_in_if;
    import bbl_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [HASH_W-1:0] key_hash;
    logic [HASH_W-1:0] key_check;
    logic [SIZE_W-1:0] file_bytes;
    logic [CODE_W-1:0] failure_code;
    modport source(output valid, kind, key_hash, key_check, file_bytes, failure_code,
                   input ready);
    modport sink(input valid, kind, key_hash, key_check, file_bytes, failure_code,
                 output ready);
endinterface

// File: src/bbl_out_if.sv
interface bbl_out_if;
    import bbl_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [CODE_W-1:0] failure_out;
    logic              collision;
    logic              evicted;
    logic [HASH_W-1:0] evicted_hash;
    logic              last;
    modport source(output valid, status, failure_out, collision, evicted, evicted_hash,
                   last, input ready);
    modport sink(input valid, status, failure_out, collision, evicted, evicted_hash,
                 last, output ready);
endinterface

// File: src/bbl_cfg_if.sv
interface bbl_cfg_if;
    import bbl_pkg::*;
    logic                valid;
    logic                ready;
    logic [BUDGET_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// File: src/bbl_ram.sv
module bbl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/bbl_scan.sv
module bbl_scan #(
    parameter int unsigned ENTRIES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_clr,
    input  logic                       i_en,
    input  logic [$clog2(ENTRIES)-1:0] i_idx,
    input  logic                       i_vld,
    input  bbl_pkg::t_entry            i_data,
    input  logic [63:0]                i_hash,
    input  logic                       i_trim,
    output bbl_pkg::t_scan             o_scan,
    output logic [$clog2(ENTRIES)-1:0] o_match_idx,
    output logic [$clog2(ENTRIES)-1:0] o_free_idx,
    output logic [$clog2(ENTRIES)-1:0] o_old_idx
);
    import bbl_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);

    t_scan         r_scan;
    logic [IW-1:0] r_match_idx;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_old_idx;
    logic          w_cand;
    logic          w_older;

    assign w_cand  = i_vld && (i_data.ready || !i_trim);
    assign w_older = !r_scan.old_found || (i_data.tick < r_scan.old_entry.tick);

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_scan.match_found <= 1'b0;
            r_scan.free_found  <= 1'b0;
            r_scan.old_found   <= 1'b0;
        end else if (i_en) begin
            if (i_vld && i_data.hash == i_hash && !r_scan.match_found) begin
                r_scan.match_found <= 1'b1;
                r_scan.match_entry <= i_data;
                r_match_idx        <= i_idx;
            end
            if (!i_vld && !r_scan.free_found) begin
                r_scan.free_found <= 1'b1;
                r_free_idx        <= i_idx;
            end
            if (w_cand && w_older) begin
                r_scan.old_found <= 1'b1;
                r_scan.old_entry <= i_data;
                r_old_idx        <= i_idx;
            end
        end
    end

    assign o_scan      = r_scan;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_old_idx   = r_old_idx;
endmodule

// File: src/byte_budget_lru_table_unit.sv
// Directory of ENTRIES entries held in one table memory that is scanned one entry per cycle.
// A lookup or a mark failed makes one full scan of the table before the next accept, and a
// mark ready also checks the budget after its scan. Every entry evicted to meet the budget adds a
// further scan, and the sink holding back result words can stall the unit. Rebuild needs no
// scan. The table scan through the one memory read port dominates this cost.
module byte_budget_lru_table_unit #(
    parameter int unsigned ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbl_in_if.sink     i_in,
    bbl_out_if.source  o_out,
    bbl_cfg_if.sink    i_cfg
);
    import bbl_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LOOK, S_CLAIM, S_TRIM_CHK, S_TRIM_DO, S_FLUSH
    } t_state;

    t_state              r_state;
    logic [ENTRIES-1:0]  r_valid;
    logic [TOTAL_W-1:0]  r_total;
    logic [TICK_W-1:0]   r_tick;
    logic [BUDGET_W-1:0] r_budget;
    logic [1:0]          r_kind;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   r_check;
    logic [SIZE_W-1:0]   r_size;
    logic [CODE_W-1:0]   r_code;
    logic                r_trim;
    logic                r_issue;
    logic [IW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic                r_pend_v;
    t_result             r_pend;
    logic                r_ovld;
    t_result             r_out;
    logic                r_olast;

    t_entry              w_rdata;
    t_scan               w_scan;
    logic [IW-1:0]       w_match_idx;
    logic [IW-1:0]       w_free_idx;
    logic [IW-1:0]       w_old_idx;
    logic                w_clr;
    logic                w_slot_free;
    logic [TOTAL_W-1:0]  w_limit;
    logic                w_we;
    logic [IW-1:0]       w_slot;
    t_entry              w_wentry;
    logic                w_drop;
    logic [TOTAL_W-1:0]  w_drop_size;
    logic [TOTAL_W-1:0]  w_after_drop;
    logic [TOTAL_W-1:0]  w_old_size;
    logic [TOTAL_W-1:0]  w_trim_total;
    logic                w_claim_evict;
    t_result             w_plain;
    t_result             w_evict;
    t_result             w_look;
    logic [TICK_W-1:0]   w_next_tick;
    logic                w_load;

    assign w_limit     = {r_budget, {MIB_SHIFT{1'b0}}};
    assign w_slot_free = !r_ovld || o_out.ready;
    assign w_clr       = (r_state == S_IDLE && i_in.valid && i_in.kind != KIND_REBUILD)
                      || (r_state == S_TRIM_CHK && r_total > w_limit);
    assign w_next_tick = r_tick + 1'b1;
    assign w_plain     = '0;
    assign w_load      = (r_state == S_FLUSH && w_slot_free)
                      || (r_state == S_TRIM_DO && w_scan.old_found && r_pend_v && w_slot_free);

    always_comb begin
        w_evict              = '0;
        w_evict.evicted      = 1'b1;
        w_evict.evicted_hash = w_scan.old_entry.hash;
    end

    always_comb begin
        w_look = '0;
        if (!w_scan.match_found) begin
            w_look.status = ST_MISSING;
        end else if (w_scan.match_entry.check != r_check) begin
            w_look.collision = 1'b1;
        end else if (w_scan.match_entry.ready) begin
            w_look.status = ST_READY;
        end else begin
            w_look.status      = ST_FAILED;
            w_look.failure_out = w_scan.match_entry.reason;
        end
    end

    always_comb begin
        w_claim_evict = 1'b0;
        if (w_scan.match_found) begin
            w_slot      = w_match_idx;
            w_drop      = w_scan.match_entry.ready;
            w_drop_size = TOTAL_W'(w_scan.match_entry.size);
        end else if (w_scan.free_found) begin
            w_slot      = w_free_idx;
            w_drop      = 1'b0;
            w_drop_size = '0;
        end else begin
            w_slot        = w_old_idx;
            w_drop        = w_scan.old_entry.ready;
            w_drop_size   = TOTAL_W'(w_scan.old_entry.size);
            w_claim_evict = w_scan.old_entry.ready;
        end
        if (!w_drop) begin
            w_after_drop = r_total;
        end else if (w_drop_size < r_total) begin
            w_after_drop = r_total - w_drop_size;
        end else begin
            w_after_drop = '0;
        end
    end

    assign w_old_size   = TOTAL_W'(w_scan.old_entry.size);
    assign w_trim_total = (w_old_size < r_total) ? (r_total - w_old_size) : '0;

    always_comb begin
        w_wentry.hash  = r_hash;
        w_wentry.check = r_check;
        w_wentry.tick  = w_next_tick;
        if (r_kind == KIND_READY) begin
            w_wentry.ready  = 1'b1;
            w_wentry.reason = '0;
            w_wentry.size   = r_size;
        end else begin
            w_wentry.ready  = 1'b0;
            w_wentry.reason = r_code;
            w_wentry.size   = '0;
        end
    end

    assign w_we = (r_state == S_CLAIM);

    bbl_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_slot),
        .i_wdata(w_wentry),
        .i_re   (r_issue),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    bbl_scan #(
        .ENTRIES(ENTRIES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_clr      (w_clr),
        .i_en       (r_rd_vld),
        .i_idx      (r_rd_idx),
        .i_vld      (r_valid[r_rd_idx]),
        .i_data     (w_rdata),
        .i_hash     (r_hash),
        .i_trim     (r_trim),
        .o_scan     (w_scan),
        .o_match_idx(w_match_idx),
        .o_free_idx (w_free_idx),
        .o_old_idx  (w_old_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_tick   <= '0;
            r_budget <= BUDGET_RESET;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_pend_v <= 1'b0;
            r_ovld   <= 1'b0;
            r_trim   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_budget <= i_cfg.data;
            end
            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && o_out.ready) begin
                r_ovld <= 1'b0;
            end
            r_rd_vld <= r_issue;
            r_rd_idx <= r_addr;
            if (r_issue) begin
                if (r_addr == IW'(ENTRIES - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_hash  <= i_in.key_hash;
                        r_check <= i_in.key_check;
                        r_size  <= i_in.file_bytes;
                        r_code  <= i_in.failure_code;
                        r_trim  <= 1'b0;
                        if (i_in.kind == KIND_REBUILD) begin
                            r_valid  <= '0;
                            r_total  <= '0;
                            r_tick   <= '0;
                            r_pend_v <= 1'b0;
                            r_state  <= S_FLUSH;
                        end else begin
                            r_issue <= 1'b1;
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld && r_rd_idx == IW'(ENTRIES - 1)) begin
                        if (r_trim) begin
                            r_state <= S_TRIM_DO;
                        end else if (r_kind == KIND_LOOKUP) begin
                            r_state <= S_LOOK;
                        end else begin
                            r_state <= S_CLAIM;
                        end
                    end
                end
                S_LOOK: begin
                    r_pend   <= w_look;
                    r_pend_v <= 1'b1;
                    r_state  <= S_FLUSH;
                end
                S_CLAIM: begin
                    r_valid[w_slot] <= 1'b1;
                    r_tick          <= w_next_tick;
                    if (r_kind == KIND_READY) begin
                        r_total <= w_after_drop + TOTAL_W'(r_size);
                        r_state <= S_TRIM_CHK;
                    end else begin
                        r_total <= w_after_drop;
                        r_state <= S_FLUSH;
                    end
                    if (w_claim_evict) begin
                        r_pend_v <= 1'b1;
                        r_pend   <= w_evict;
                    end
                end
                S_TRIM_CHK: begin
                    if (r_total > w_limit) begin
                        r_trim  <= 1'b1;
                        r_issue <= 1'b1;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_TRIM_DO: begin
                    if (!w_scan.old_found) begin
                        r_state <= S_FLUSH;
                    end else if (!r_pend_v || w_slot_free) begin
                        if (r_pend_v) begin
                            r_out   <= r_pend;
                            r_olast <= 1'b0;
                        end
                        r_pend_v           <= 1'b1;
                        r_pend             <= w_evict;
                        r_valid[w_old_idx] <= 1'b0;
                        r_total            <= w_trim_total;
                        r_state            <= S_TRIM_CHK;
                    end
                end
                S_FLUSH: begin
                    if (w_slot_free) begin
                        r_out    <= r_pend_v ? r_pend : w_plain;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_ovld;
    assign o_out.status       = r_out.status;
    assign o_out.failure_out  = r_out.failure_out;
    assign o_out.collision    = r_out.collision;
    assign o_out.evicted      = r_out.evicted;
    assign o_out.evicted_hash = r_out.evicted_hash;
    assign o_out.last         = r_olast;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_pend_v)
        else $error("pending word left over in idle");

    a_rebuild_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind == KIND_REBUILD) |=>
            (r_total == '0 && r_valid == '0))
        else $error("rebuild did not clear the table");

    a_evict_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.evicted) |-> (o_out.status == ST_MISSING && !o_out.collision))
        else $error("evicted word carries lookup fields");

    a_trim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && $past(r_state) == S_TRIM_CHK) |-> (r_total <= w_limit))
        else $error("trim ended over budget");
endmodule
